>>> sv/bs3_pkg.sv
// ----------------------------------------------------------------------------
// bs3_pkg
// Shared constants and types for the 3x3 zero-padded box sum.
// ----------------------------------------------------------------------------
package bs3_pkg;

	localparam int DEF_MAX_SIDE    = 128;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int SIDE_W          = 8;
	localparam int SIDE_RESET      = 3;
	localparam int SUM_OUT_W       = 20;
	localparam int POS_OUT_W       = 7;
	localparam int OUT_FIELDS_W    = SUM_OUT_W + 2 * POS_OUT_W;
	localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Position flags of one sample, handed from the input stage to the emitter.
	typedef struct packed {
		logic up;  // a row above exists, so the upper centre row is complete
		logic dn;  // bottom row: the sample's own row is complete as well
		logic lf;  // a column to the left exists
		logic rt;  // rightmost column
		logic c2;  // two columns to the left exist
	} bs3_item_t;

endpackage

>>> sv/bs3_line_buf.sv
// ----------------------------------------------------------------------------
// bs3_line_buf
// Two-row line store: each word holds the previous row and the one before it
// at one column. Registered read, one write port.
// ----------------------------------------------------------------------------
module bs3_line_buf #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// A read of the word written in the same cycle sees the new data.
		if (rd_en) begin
			rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
		end
	end

endmodule

>>> sv/bs3_emit.sv
// ----------------------------------------------------------------------------
// bs3_emit
// Holds the column sums of the current and two previous columns and sends out
// the zero to four box sums that one sample completes, one per transaction.
// ----------------------------------------------------------------------------
module bs3_emit #(
	parameter int SAMPLE_BITS = 16,
	parameter int POS_W       = 7
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	output logic                                   ready,
	input  bs3_pkg::bs3_item_t                     item,
	input  logic signed [SAMPLE_BITS+1:0]          cs_up,
	input  logic signed [SAMPLE_BITS+1:0]          cs_dn,
	input  logic [POS_W-1:0]                       row,
	input  logic [POS_W-1:0]                       col,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [bs3_pkg::OUT_TDATA_W-1:0]        m_tdata, // sum[19:0], out_row, out_col
	output logic                                   m_tlast
);
	import bs3_pkg::*;

	localparam int COL_W = SAMPLE_BITS + 2;
	localparam int SW    = SAMPLE_BITS + 4;
	localparam int XW    = (SW > SUM_OUT_W) ? SW : SUM_OUT_W;
	localparam int PX    = (POS_W > POS_OUT_W) ? POS_W : POS_OUT_W;
	localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

	logic signed [COL_W-1:0] u_s2 [3];
	logic signed [COL_W-1:0] d_s2 [3];
	logic [POS_W-1:0]        row_s2;
	logic [POS_W-1:0]        col_s2;
	// Pending sums: up-left, up-right, down-left, down-right from bit 0.
	logic [3:0]              pend_s2;

	logic                    emit;
	logic                    sel_up;
	logic                    sel_left;
	logic signed [COL_W-1:0] a0, a1, a2;
	logic signed [SW-1:0]    sum;
	logic signed [XW-1:0]    sum_x;
	logic [POS_W-1:0]        row_o;
	logic [POS_W-1:0]        col_o;
	logic [PX-1:0]           row_x;
	logic [PX-1:0]           col_x;

	assign emit  = (pend_s2 != 4'd0) && (!m_tvalid || m_tready);
	assign ready = ((pend_s2 & (pend_s2 - 4'd1)) == 4'd0) && ((pend_s2 == 4'd0) || emit);

	always_comb begin
		priority if (pend_s2[0]) begin
			sel_up   = 1'b1;
			sel_left = 1'b1;
		end else if (pend_s2[1]) begin
			sel_up   = 1'b1;
			sel_left = 1'b0;
		end else if (pend_s2[2]) begin
			sel_up   = 1'b0;
			sel_left = 1'b1;
		end else begin
			sel_up   = 1'b0;
			sel_left = 1'b0;
		end
	end

	// A left-column sum is centred one column back and spans three columns;
	// a rightmost-column sum has nothing to its right.
	assign a0    = sel_up ? u_s2[0] : d_s2[0];
	assign a1    = sel_up ? u_s2[1] : d_s2[1];
	assign a2    = sel_left ? (sel_up ? u_s2[2] : d_s2[2]) : '0;
	assign sum   = SW'(a0) + SW'(a1) + SW'(a2);
	assign sum_x = XW'(sum);
	assign row_o = row_s2 - POS_W'(sel_up);
	assign col_o = col_s2 - POS_W'(sel_left);
	assign row_x = PX'(row_o);
	assign col_x = PX'(col_o);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= 4'd0;
		end else if (load) begin
			pend_s2 <= {item.dn & item.rt, item.dn & item.lf, item.up & item.rt, item.up & item.lf};
		end else if (emit) begin
			pend_s2 <= pend_s2 & (pend_s2 - 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			u_s2[0] <= cs_up;
			u_s2[1] <= item.lf ? u_s2[0] : '0;
			u_s2[2] <= item.c2 ? u_s2[1] : '0;
			d_s2[0] <= cs_dn;
			d_s2[1] <= item.lf ? d_s2[0] : '0;
			d_s2[2] <= item.c2 ? d_s2[1] : '0;
			row_s2  <= row;
			col_s2  <= col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= {{PAD_W{1'b0}}, col_x[POS_OUT_W-1:0], row_x[POS_OUT_W-1:0],
				sum_x[SUM_OUT_W-1:0]};
			m_tlast <= !sel_up && !sel_left;
		end
	end

	a_last_on_diagonal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |->
		m_tdata[SUM_OUT_W+POS_OUT_W-1:SUM_OUT_W] == m_tdata[OUT_FIELDS_W-1:SUM_OUT_W+POS_OUT_W])
		else $error("last sum is not on the diagonal");

	a_pend_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s2 != 4'd0) && m_tvalid && !m_tready |=> $stable(pend_s2))
		else $error("pending sums changed while output stalled");

endmodule

>>> sv/box_sum_3x3_zero_pad.sv
// ----------------------------------------------------------------------------
// box_sum_3x3_zero_pad
// 3x3 box sum with zero padding over a square image streamed in raster order.
// ----------------------------------------------------------------------------
// The block takes one sample per clock unless the output stalls or a sample
// holds the input back. Each sample is written to a two-row line store
// (MAX_SIDE words of two samples each) and combined with the two samples
// above it into column sums; a sum is offered on the output once its
// lower-right neighbour has arrived, by way of the input stage, the emitter's
// column registers and the output register. A sample that completes more
// than one sum holds the input back, since all sums leave through one output
// register: two sums for the last column or the last row, four for the
// bottom-right corner when the side is 2 or more. Writing side restarts the
// frame; 0 is taken as 1 and values above MAX_SIDE as MAX_SIDE.
// ----------------------------------------------------------------------------
module box_sum_3x3_zero_pad #(
	parameter int MAX_SIDE    = bs3_pkg::DEF_MAX_SIDE,
	parameter int SAMPLE_BITS = bs3_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [bs3_pkg::SIDE_W-1:0]            cfg_wr_data, // side
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,     // pixel
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [bs3_pkg::OUT_TDATA_W-1:0]       m_tdata,     // sum, out_row, out_col
	output logic                                  m_tlast
);
	import bs3_pkg::*;

	localparam int POS_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int COL_W = SAMPLE_BITS + 2;
	localparam logic [POS_W-1:0] LAST_RST =
		POS_W'(((SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET) - 1);

	logic [POS_W-1:0]              last_q;
	logic [POS_W-1:0]              cfg_last;
	logic [POS_W-1:0]              row_q;
	logic [POS_W-1:0]              col_q;
	logic                          accept;
	logic                          adv;
	logic                          s2_ready;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] pix_s1;
	logic [POS_W-1:0]              row_s1;
	logic [POS_W-1:0]              col_s1;
	logic                          r2_s1;
	bs3_item_t                     item_s1;
	logic [2*SAMPLE_BITS-1:0]      rd_data;

	logic signed [SAMPLE_BITS-1:0] above1;
	logic signed [SAMPLE_BITS-1:0] above2;
	logic signed [COL_W-1:0]       cs_up;
	logic signed [COL_W-1:0]       cs_dn;

	always_comb begin
		priority if (cfg_wr_data == '0) begin
			cfg_last = '0;
		end else if (int'(cfg_wr_data) > MAX_SIDE) begin
			cfg_last = POS_W'(MAX_SIDE - 1);
		end else begin
			cfg_last = POS_W'(cfg_wr_data - 1'b1);
		end
	end

	assign accept   = s_tvalid && s_tready;
	assign adv      = valid_s1 && s2_ready;
	assign s_tready = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= LAST_RST;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_wr_en) begin
			last_q <= cfg_last;
			row_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			if (col_q == last_q) begin
				col_q <= '0;
				row_q <= (row_q == last_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= s_tdata[SAMPLE_BITS-1:0];
			row_s1     <= row_q;
			col_s1     <= col_q;
			r2_s1      <= row_q > POS_W'(1);
			item_s1.up <= row_q != '0;
			item_s1.dn <= row_q == last_q;
			item_s1.lf <= col_q != '0;
			item_s1.rt <= col_q == last_q;
			item_s1.c2 <= col_q > POS_W'(1);
		end
	end

	// Word layout: upper half is the row above, lower half two rows above.
	bs3_line_buf #(
		.DEPTH (MAX_SIDE),
		.AW    (POS_W),
		.DW    (2 * SAMPLE_BITS)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (adv),
		.wr_addr (col_s1),
		.wr_data ({pix_s1, rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]})
	);

	// Rows above the image count as zero; this also hides line store words
	// left from before the current frame.
	assign above1 = item_s1.up ? rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
	assign above2 = r2_s1 ? rd_data[SAMPLE_BITS-1:0] : '0;
	assign cs_up  = COL_W'(above2) + COL_W'(above1) + COL_W'(pix_s1);
	assign cs_dn  = COL_W'(above1) + COL_W'(pix_s1);

	bs3_emit #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.POS_W       (POS_W)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.ready    (s2_ready),
		.item     (item_s1),
		.cs_up    (cs_up),
		.cs_dn    (cs_dn),
		.row      (row_s1),
		.col      (col_s1),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= last_q && col_q <= last_q)
		else $error("position counter beyond image side");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with empty input stage");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_wr_en && row_q == last_q && col_q == last_q |=>
		row_q == '0 && col_q == '0)
		else $error("frame did not restart after last sample");

endmodule
